// ===== rtl/pls_pkg.sv =====
// pls_pkg: shared constants, operation codes, status codes and the
// request plan struct for the positional list store. No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 6;
    localparam int VW    = 32;

    localparam logic [2:0] F_INS_FRONT = 3'd0;
    localparam logic [2:0] F_INS_BACK  = 3'd1;
    localparam logic [2:0] F_INS_AT    = 3'd2;
    localparam logic [2:0] F_DEL_FRONT = 3'd3;
    localparam logic [2:0] F_DEL_BACK  = 3'd4;
    localparam logic [2:0] F_DEL_AT    = 3'd5;
    localparam logic [2:0] F_DUMP      = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL,
        OP_DUMP
    } t_op;

    typedef struct packed {
        t_op           op;
        logic [1:0]    status;
        logic [CW-1:0] pos;
    } t_plan;

endpackage

// ===== rtl/pls_check.sv =====
// pls_check: decodes a request against the current entry count into an
// operation kind, target position and status. Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_check (
    input  logic [2:0]            i_func,
    input  logic [pls_pkg::CW-1:0] i_position,
    input  logic [pls_pkg::CW-1:0] i_count,
    output pls_pkg::t_plan        o_plan
);
    import pls_pkg::*;

    logic [CW-1:0] w_ins_pos;
    logic [CW-1:0] w_del_pos;

    always_comb begin
        w_ins_pos = (i_func == F_INS_FRONT) ? '0 :
                    (i_func == F_INS_BACK)  ? i_count : i_position;
        w_del_pos = (i_func == F_DEL_FRONT) ? '0 :
                    (i_func == F_DEL_BACK)  ? CW'(i_count - 1'b1) : i_position;
        o_plan = '{op: OP_NONE, status: ST_OK, pos: '0};
        unique case (i_func) inside
            F_INS_FRONT, F_INS_BACK, F_INS_AT: begin
                o_plan.op  = OP_INS;
                o_plan.pos = w_ins_pos;
                if (w_ins_pos > i_count) begin
                    o_plan.status = ST_BADPOS;
                end else if (i_count >= CW'(DEPTH)) begin
                    o_plan.status = ST_FULL;
                end
            end
            F_DEL_FRONT, F_DEL_BACK, F_DEL_AT: begin
                o_plan.op  = OP_DEL;
                o_plan.pos = w_del_pos;
                if (i_count == '0) begin
                    o_plan.status = ST_EMPTY;
                end else if (w_del_pos >= i_count) begin
                    o_plan.status = ST_BADPOS;
                end
            end
            F_DUMP: begin
                o_plan.op = OP_DUMP;
                if (i_count == '0) begin
                    o_plan.status = ST_EMPTY;
                end
            end
            default: begin
                o_plan.op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/positional_list_store_top.sv =====
// positional_list_store_top: bounded ordered list held in a single-port
// entry memory with registered read; a small sequencer shifts one entry at a time.
// Depends on pls_pkg and pls_check.
// Insert at p shifts entries p and up one slot up, then writes the value;
// delete at p reads entry p, then shifts later ones down. Errors and an empty
// dump go straight to the result; a dump gives one beat per entry. One request
// at a time: ready only while idle. Reset clears count and control, not entries.
`timescale 1ns / 1ps

module positional_list_store_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_func,
    input  logic signed [pls_pkg::VW-1:0] i_value,
    input  logic [pls_pkg::CW-1:0]        i_position,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic                          o_has_value,
    output logic signed [pls_pkg::VW-1:0] o_out_value,
    output logic [pls_pkg::CW-1:0]        o_entry_count,
    output logic                          o_last
);
    import pls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_GET,
        S_DEL_SRD,
        S_DEL_SWR,
        S_DONE,
        S_DMP_RD,
        S_DMP_LD
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_idx;
    logic signed [VW-1:0] r_value;
    logic [VW-1:0]        r_got;
    logic [1:0]           r_status;
    logic                 r_hv;

    logic                 r_o_valid;
    logic [1:0]           r_o_status;
    logic                 r_o_hv;
    logic [VW-1:0]        r_o_value;
    logic [CW-1:0]        r_o_count;
    logic                 r_o_last;

    logic [VW-1:0]        r_mem [DEPTH];
    logic [VW-1:0]        r_rdata;

    t_plan                w_plan;
    logic                 w_slot;
    logic                 w_we;
    logic                 w_re;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [VW-1:0]        w_wdata;
    logic [CW-1:0]        w_idx_dn;
    logic [CW-1:0]        w_idx_up;

    pls_check u_check (
        .i_func     (i_func),
        .i_position (i_position),
        .i_count    (r_count),
        .o_plan     (w_plan)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_has_value   = r_o_hv;
    assign o_out_value   = r_o_value;
    assign o_entry_count = r_o_count;
    assign o_last        = r_o_last;

    assign w_slot   = !r_o_valid || i_ready;
    assign w_idx_dn = CW'(r_idx - 1'b1);
    assign w_idx_up = CW'(r_idx + 1'b1);

    always_comb begin
        w_re    = 1'b0;
        w_we    = 1'b0;
        w_raddr = '0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_rdata;
        unique case (r_state)
            S_INS_RD: begin
                w_re    = 1'b1;
                w_raddr = w_idx_dn[AW-1:0];
            end
            S_INS_WR: begin
                w_we = 1'b1;
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_value;
            end
            S_DEL_RD: begin
                w_re    = 1'b1;
                w_raddr = r_pos[AW-1:0];
            end
            S_DEL_SRD: begin
                w_re    = 1'b1;
                w_raddr = w_idx_up[AW-1:0];
            end
            S_DEL_SWR: begin
                w_we = 1'b1;
            end
            S_DMP_RD: begin
                w_re    = 1'b1;
                w_raddr = r_idx[AW-1:0];
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && r_state != S_DONE && r_state != S_DMP_LD) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_value  <= i_value;
                        r_pos    <= w_plan.pos;
                        r_status <= w_plan.status;
                        r_hv     <= 1'b0;
                        r_idx    <= r_count;
                        case (w_plan.op)
                            OP_INS: begin
                                if (w_plan.status != ST_OK) begin
                                    r_state <= S_DONE;
                                end else if (w_plan.pos == r_count) begin
                                    r_state <= S_INS_PUT;
                                end else begin
                                    r_state <= S_INS_RD;
                                end
                            end
                            OP_DEL: begin
                                r_state <= (w_plan.status == ST_OK) ? S_DEL_RD : S_DONE;
                            end
                            OP_DUMP: begin
                                r_idx   <= '0;
                                r_state <= (w_plan.status == ST_OK) ? S_DMP_RD : S_DONE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_idx   <= w_idx_dn;
                    r_state <= (w_idx_dn == r_pos) ? S_INS_PUT : S_INS_RD;
                end
                S_INS_PUT: begin
                    r_count <= CW'(r_count + 1'b1);
                    r_state <= S_DONE;
                end
                S_DEL_RD: begin
                    r_state <= S_DEL_GET;
                end
                S_DEL_GET: begin
                    r_got <= r_rdata;
                    r_hv  <= 1'b1;
                    r_idx <= r_pos;
                    if (CW'(r_pos + 1'b1) < r_count) begin
                        r_state <= S_DEL_SRD;
                    end else begin
                        r_count <= CW'(r_count - 1'b1);
                        r_state <= S_DONE;
                    end
                end
                S_DEL_SRD: begin
                    r_state <= S_DEL_SWR;
                end
                S_DEL_SWR: begin
                    r_idx <= w_idx_up;
                    if (CW'(r_idx + 2'd2) < r_count) begin
                        r_state <= S_DEL_SRD;
                    end else begin
                        r_count <= CW'(r_count - 1'b1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_hv     <= r_hv;
                        r_o_value  <= r_hv ? r_got : '0;
                        r_o_count  <= r_count;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_DMP_RD: begin
                    r_state <= S_DMP_LD;
                end
                S_DMP_LD: begin
                    if (w_slot) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= ST_OK;
                        r_o_hv     <= 1'b1;
                        r_o_value  <= r_rdata;
                        r_o_count  <= r_count;
                        r_o_last   <= (w_idx_up == r_count);
                        r_idx      <= w_idx_up;
                        r_state    <= (w_idx_up == r_count) ? S_IDLE : S_DMP_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == CW'($past(r_count) + 1'b1) ||
                            r_count == CW'($past(r_count) - 1'b1)))
        else $error("entry count moved by more than one");

    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (!o_has_value && o_out_value == '0))
        else $error("error beat carries a value");

    a_no_mem_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("memory read and write in the same cycle");

    a_idle_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> (!w_we && !w_re))
        else $error("memory access while not shifting");

endmodule
